// File: sv/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg: shared types for the cursor array list
// Command and status codes, sequencer states and the response word layout.
// ----------------------------------------------------------------------------
package cal_pkg;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_START  = 3'd2,
		CMD_END    = 3'd3,
		CMD_PREV   = 3'd4,
		CMD_NEXT   = 3'd5,
		CMD_MOVE   = 3'd6,
		CMD_READ   = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_AT_END = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_LAST,
		S_INS_PUT,
		S_RM_RD,
		S_RM_LAST
	} state_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		status_t                   status;
		logic [POS_W-1:0]          length;
		logic [POS_W-1:0]          cursor;
	} rsp_t;

endpackage

// File: sv/cal_if.sv
// ----------------------------------------------------------------------------
// cal_if: request and response channels of the cursor array list
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cal_req_if;
	logic                                 valid;
	logic                                 ready;
	cal_pkg::cmd_t                        command;
	logic signed [cal_pkg::VALUE_W-1:0]   value;
	logic [cal_pkg::POS_W-1:0]            position;

	modport source(output valid, command, value, position, input ready);
	modport sink(input valid, command, value, position, output ready);
endinterface

interface cal_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cal_pkg::VALUE_W-1:0]   result_value;
	cal_pkg::status_t                     status;
	logic [cal_pkg::POS_W-1:0]            length;
	logic [cal_pkg::POS_W-1:0]            cursor;

	modport source(output valid, result_value, status, length, cursor, input ready);
	modport sink(input valid, result_value, status, length, cursor, output ready);
endinterface

// File: sv/cal_store.sv
// ----------------------------------------------------------------------------
// cal_store: item memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cal_store #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(DEPTH)-1:0]            wr_addr,
	input  logic [cal_pkg::VALUE_W-1:0]         wr_data,
	input  logic                                rd_en,
	input  logic [$clog2(DEPTH)-1:0]            rd_addr,
	output logic [cal_pkg::VALUE_W-1:0]         rd_data
);

	logic [cal_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/cal_seq.sv
// ----------------------------------------------------------------------------
// cal_seq: command sequencer
// Holds length and cursor and walks the memory to shift entries.
// ----------------------------------------------------------------------------
module cal_seq #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  cal_pkg::cmd_t                       cmd,
	input  logic signed [cal_pkg::VALUE_W-1:0]  value,
	input  logic [cal_pkg::POS_W-1:0]           position,
	output logic                                busy,
	output logic                                rd_en,
	output logic [$clog2(CAPACITY)-1:0]         rd_addr,
	input  logic [cal_pkg::VALUE_W-1:0]         rd_data,
	output logic                                wr_en,
	output logic [$clog2(CAPACITY)-1:0]         wr_addr,
	output logic [cal_pkg::VALUE_W-1:0]         wr_data,
	output logic                                done,
	output cal_pkg::rsp_t                       rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = cal_pkg::POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	cal_pkg::state_t state_q, state_d;

	logic [CW-1:0]               count_q, count_d;
	logic [CW-1:0]               cur_q, cur_d;
	logic [AW-1:0]               ptr_q;
	logic                        is_rm_q;
	logic [cal_pkg::VALUE_W-1:0] val_q;
	logic [cal_pkg::VALUE_W-1:0] res_q;
	logic                        rdv_s1;
	logic [AW-1:0]               raddr_s1;

	logic [CW-1:0]       ptr_ext;
	logic [CW-1:0]       count_m1;
	logic [CW+PW-1:0]    pos_ext, cnt_ext, len_w, cur_w;
	logic                full, hit_s1;

	assign ptr_ext  = CW'(ptr_q);
	assign count_m1 = count_q - CW'(1);
	assign full     = (count_q >= CAP_C);
	assign pos_ext  = {{CW{1'b0}}, position};
	assign cnt_ext  = {{PW{1'b0}}, count_q};
	assign hit_s1   = (raddr_s1 == cur_q[AW-1:0]);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cal_pkg::S_IDLE: begin
				if (start) begin
					case (cmd)
						cal_pkg::CMD_INSERT: begin
							if (!full) begin
								state_d = (cur_q == count_q) ? cal_pkg::S_INS_PUT
								                             : cal_pkg::S_INS_RD;
							end
						end
						cal_pkg::CMD_REMOVE, cal_pkg::CMD_READ: begin
							if (count_q != '0 && cur_q < count_q) begin
								state_d = cal_pkg::S_RM_RD;
							end
						end
						default: state_d = cal_pkg::S_IDLE;
					endcase
				end
			end
			cal_pkg::S_INS_RD: begin
				if (ptr_ext == cur_q) begin
					state_d = cal_pkg::S_INS_LAST;
				end
			end
			cal_pkg::S_INS_LAST: state_d = cal_pkg::S_INS_PUT;
			cal_pkg::S_INS_PUT:  state_d = cal_pkg::S_IDLE;
			cal_pkg::S_RM_RD: begin
				if (!is_rm_q || ptr_ext == count_m1) begin
					state_d = cal_pkg::S_RM_LAST;
				end
			end
			cal_pkg::S_RM_LAST: state_d = cal_pkg::S_IDLE;
			default: state_d = cal_pkg::S_IDLE;
		endcase
	end

	// Outputs: memory access, updated length and cursor, response word.
	always_comb begin
		rd_en             = 1'b0;
		rd_addr           = ptr_q;
		wr_en             = 1'b0;
		wr_addr           = cur_q[AW-1:0];
		wr_data           = val_q;
		count_d           = count_q;
		cur_d             = cur_q;
		rsp.result_value  = '0;
		rsp.status        = cal_pkg::ST_OK;
		done              = 1'b0;

		case (state_q)
			cal_pkg::S_IDLE: begin
				if (start) begin
					done = (state_d == cal_pkg::S_IDLE);
					case (cmd)
						cal_pkg::CMD_INSERT: begin
							if (full) begin
								rsp.status = cal_pkg::ST_FULL;
							end
						end
						cal_pkg::CMD_REMOVE, cal_pkg::CMD_READ: begin
							if (count_q == '0) begin
								rsp.status = cal_pkg::ST_EMPTY;
							end else if (cur_q >= count_q) begin
								rsp.status = cal_pkg::ST_AT_END;
							end
						end
						cal_pkg::CMD_START: cur_d = '0;
						cal_pkg::CMD_END:   cur_d = (count_q == '0) ? '0 : count_m1;
						cal_pkg::CMD_PREV: begin
							if (cur_q != '0) begin
								cur_d = cur_q - CW'(1);
							end
						end
						cal_pkg::CMD_NEXT: begin
							if (cur_q < count_q) begin
								cur_d = cur_q + CW'(1);
							end
						end
						cal_pkg::CMD_MOVE: begin
							if (pos_ext < cnt_ext) begin
								cur_d = pos_ext[CW-1:0];
							end
						end
						default: cur_d = cur_q;
					endcase
				end
			end
			cal_pkg::S_INS_RD: begin
				rd_en = 1'b1;
				if (rdv_s1) begin
					wr_en   = 1'b1;
					wr_addr = raddr_s1 + AW'(1);
					wr_data = rd_data;
				end
			end
			cal_pkg::S_INS_LAST: begin
				if (rdv_s1) begin
					wr_en   = 1'b1;
					wr_addr = raddr_s1 + AW'(1);
					wr_data = rd_data;
				end
			end
			cal_pkg::S_INS_PUT: begin
				wr_en   = 1'b1;
				count_d = count_q + CW'(1);
				done    = 1'b1;
			end
			cal_pkg::S_RM_RD: begin
				rd_en = 1'b1;
				if (rdv_s1 && is_rm_q && !hit_s1) begin
					wr_en   = 1'b1;
					wr_addr = raddr_s1 - AW'(1);
					wr_data = rd_data;
				end
			end
			cal_pkg::S_RM_LAST: begin
				if (rdv_s1 && is_rm_q && !hit_s1) begin
					wr_en   = 1'b1;
					wr_addr = raddr_s1 - AW'(1);
					wr_data = rd_data;
				end
				rsp.result_value = (rdv_s1 && hit_s1) ? rd_data : res_q;
				if (is_rm_q) begin
					count_d = count_m1;
				end
				done = 1'b1;
			end
			default: done = 1'b0;
		endcase

		// Length and cursor go out as nine-bit fields.
		len_w      = {{PW{1'b0}}, count_d};
		cur_w      = {{PW{1'b0}}, cur_d};
		rsp.length = len_w[PW-1:0];
		rsp.cursor = cur_w[PW-1:0];
	end

	assign busy = (state_q != cal_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cal_pkg::S_IDLE;
			count_q <= '0;
			cur_q   <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cur_q   <= cur_d;
			rdv_s1  <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			raddr_s1 <= ptr_q;
		end
		if (rdv_s1 && state_q == cal_pkg::S_RM_RD && hit_s1) begin
			res_q <= rd_data;
		end
		case (state_q)
			cal_pkg::S_IDLE: begin
				if (start) begin
					is_rm_q <= (cmd == cal_pkg::CMD_REMOVE);
					val_q   <= value;
					ptr_q   <= (cmd == cal_pkg::CMD_INSERT) ? count_m1[AW-1:0]
					                                         : cur_q[AW-1:0];
				end
			end
			cal_pkg::S_INS_RD: ptr_q <= ptr_q - AW'(1);
			cal_pkg::S_RM_RD:  ptr_q <= ptr_q + AW'(1);
			default:           ptr_q <= ptr_q;
		endcase
	end

endmodule

// File: sv/cursor_array_list.sv
// ----------------------------------------------------------------------------
// cursor_array_list: ordered list of signed words with a cursor
// Insert and remove at the cursor shift the later entries through one memory.
// ----------------------------------------------------------------------------
// Cursor moves and rejected commands: the response word is valid the cycle
// after the request word is taken. Remove and insert walk the single memory
// one entry per cycle between the cursor and the last entry (read one entry,
// write it to its neighbor the next cycle); read fetches only the entry under
// the cursor, and insert with the cursor at the end writes without a walk.
// One request is in work at a time.
// Reset clears length, cursor and the sequencer at once; memory is not cleared.
module cursor_array_list #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	cal_req_if.sink       req,
	cal_rsp_if.source     rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);

	logic                        busy;
	logic                        start;
	logic                        done;
	logic                        rd_en, wr_en;
	logic [AW-1:0]               rd_addr, wr_addr;
	logic [cal_pkg::VALUE_W-1:0] rd_data, wr_data;
	cal_pkg::rsp_t               rsp_d;
	cal_pkg::rsp_t               rsp_q;
	logic                        rsp_valid_q;

	// A new request word is taken only when the sequencer is idle and the
	// response register is free or is being emptied in the same cycle. Every
	// multi-cycle command therefore finds the register empty when it finishes.
	assign req.ready = !busy && (!rsp_valid_q || rsp.ready);
	assign start     = req.valid && req.ready;

	cal_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (req.command),
		.value    (req.value),
		.position (req.position),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.done     (done),
		.rsp      (rsp_d)
	);

	// The sequencer never reads and writes the same entry in one cycle: the
	// write lands one place away from the read it follows, so no forwarding is
	// needed around the memory.
	cal_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_q.result_value;
	assign rsp.status       = rsp_q.status;
	assign rsp.length       = rsp_q.length;
	assign rsp.cursor       = rsp_q.cursor;

endmodule

// File: sv/cal_checker.sv
// ----------------------------------------------------------------------------
// cal_checker: port-level checks for the cursor array list
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module cal_checker #(
	parameter int unsigned CAPACITY = 256
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [cal_pkg::VALUE_W-1:0]         rsp_value,
	input logic [cal_pkg::STATUS_W-1:0]        rsp_status,
	input logic [cal_pkg::POS_W-1:0]           rsp_length,
	input logic [cal_pkg::POS_W-1:0]           rsp_cursor
);

	localparam bit NARROW = (CAPACITY <= 256);

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
		&& $stable(rsp_status) && $stable(rsp_length) && $stable(rsp_cursor))
		else $error("response word changed while stalled");

	// The cursor never passes the end of the list.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && NARROW |-> rsp_cursor <= rsp_length)
		else $error("cursor beyond length");

	// An empty-list status comes with zero length and no value.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == cal_pkg::ST_EMPTY |->
		rsp_length == '0 && rsp_value == '0)
		else $error("empty status with items present");

	// A full-store status only when the store is really full.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && NARROW && rsp_status == cal_pkg::ST_FULL |->
		rsp_length == cal_pkg::POS_W'(CAPACITY) && rsp_value == '0)
		else $error("full status below capacity");

	// Nothing sits under the cursor when the at-end status is given.
	a_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == cal_pkg::ST_AT_END |->
		rsp_cursor == rsp_length && rsp_value == '0)
		else $error("at-end status with cursor inside the list");

endmodule

bind cursor_array_list cal_checker #(
	.CAPACITY(CAPACITY)
) u_cal_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.result_value),
	.rsp_status (rsp.status),
	.rsp_length (rsp.length),
	.rsp_cursor (rsp.cursor)
);
